FILE: rtl/core/nsst_pkg.sv
// ----------------------------------------------------------------------------
// Score table package
// Sizes, codes and the command word that are shared by the score table
// controller, its datapath and the top level.
// ----------------------------------------------------------------------------
package nsst_pkg;

   localparam int NUM_ENTRIES = 8;
   localparam int RANK_W      = $clog2(NUM_ENTRIES + 1);
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   localparam logic [31:0] SCORE_STEP = 32'd10;
   localparam logic [23:0] BLANK_NAME = 24'h202020;

   typedef enum logic {
      MODE_ADD  = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

FILE: rtl/core/nsst_ctrl.sv
// ----------------------------------------------------------------------------
// Score table controller
// Sequences one word at a time through capture, table update or read, and response.
// ----------------------------------------------------------------------------
module nsst_ctrl
   import nsst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_DONE);
   assign cmd.capture = start && !busy;
   assign cmd.execute = (state_ff == ST_CALC);

   a_capture_to_response: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> ##2 rsp_valid)
      else $error("accepted word did not produce a response two cycles later");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

endmodule

FILE: rtl/core/nsst_datapath.sv
// ----------------------------------------------------------------------------
// Score table datapath
// Holds the sorted table, ranks a new score against every entry at once and
// shifts the tail down to insert it, or reads one entry back.
// ----------------------------------------------------------------------------
module nsst_datapath
   import nsst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic        req_mode,
   input  logic [31:0] req_score,
   input  logic [7:0]  req_stage,
   input  logic [23:0] req_name_chars,
   input  logic [2:0]  req_read_rank,
   output logic [3:0]  rsp_placed_rank,
   output logic [31:0] rsp_entry_score,
   output logic [7:0]  rsp_entry_stage,
   output logic [23:0] rsp_entry_name
);

   mode_type    mode_ff;
   logic [31:0] score_ff;
   logic [7:0]  stage_ff;
   logic [23:0] name_ff;
   logic [2:0]  read_rank_ff;

   logic [31:0] score_tab_ff [NUM_ENTRIES];
   logic [7:0]  stage_tab_ff [NUM_ENTRIES];
   logic [23:0] name_tab_ff  [NUM_ENTRIES];
   logic [31:0] score_tab_in [NUM_ENTRIES];
   logic [7:0]  stage_tab_in [NUM_ENTRIES];
   logic [23:0] name_tab_in  [NUM_ENTRIES];
   logic [3:0]  last_rank_ff;

   logic [3:0]  placed_rank_ff;
   logic [31:0] entry_score_ff;
   logic [7:0]  entry_stage_ff;
   logic [23:0] entry_name_ff;
   logic [3:0]  placed_rank_in;
   logic [31:0] entry_score_in;
   logic [7:0]  entry_stage_in;
   logic [23:0] entry_name_in;

   logic [RANK_W-1:0] rank;
   logic [IDX_W-1:0]  read_idx;
   logic              read_ok;
   logic              sorted_ok;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff      <= mode_type'(req_mode);
         score_ff     <= req_score;
         stage_ff     <= req_stage;
         name_ff      <= req_name_chars;
         read_rank_ff <= req_read_rank;
      end
   end

   always_comb begin
      rank = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         rank = rank + RANK_W'(score_tab_ff[i] >= score_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (RANK_W'(i) < rank) begin
            score_tab_in[i] = score_tab_ff[i];
            stage_tab_in[i] = stage_tab_ff[i];
            name_tab_in[i]  = name_tab_ff[i];
         end else if (RANK_W'(i) == rank) begin
            score_tab_in[i] = score_ff;
            stage_tab_in[i] = stage_ff;
            name_tab_in[i]  = name_ff;
         end else begin
            score_tab_in[i] = score_tab_ff[(i > 0) ? i - 1 : 0];
            stage_tab_in[i] = stage_tab_ff[(i > 0) ? i - 1 : 0];
            name_tab_in[i]  = name_tab_ff[(i > 0) ? i - 1 : 0];
         end
      end
   end

   assign read_idx = IDX_W'(read_rank_ff);
   assign read_ok  = (32'(read_rank_ff) < NUM_ENTRIES);

   always_comb begin
      placed_rank_in = last_rank_ff;
      entry_score_in = '0;
      entry_stage_in = '0;
      entry_name_in  = '0;
      case (mode_ff)
         MODE_ADD: begin
            placed_rank_in = 4'(rank);
         end
         MODE_READ: begin
            if (read_ok) begin
               entry_score_in = score_tab_ff[read_idx];
               entry_stage_in = stage_tab_ff[read_idx];
               entry_name_in  = name_tab_ff[read_idx];
            end
         end
         default: begin
            placed_rank_in = last_rank_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            score_tab_ff[i] <= 32'(NUM_ENTRIES - i) * SCORE_STEP;
            stage_tab_ff[i] <= '0;
            name_tab_ff[i]  <= BLANK_NAME;
         end
         last_rank_ff <= 4'(NUM_ENTRIES);
      end else if (cmd.execute && (mode_ff == MODE_ADD)) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            score_tab_ff[i] <= score_tab_in[i];
            stage_tab_ff[i] <= stage_tab_in[i];
            name_tab_ff[i]  <= name_tab_in[i];
         end
         last_rank_ff <= 4'(rank);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         placed_rank_ff <= placed_rank_in;
         entry_score_ff <= entry_score_in;
         entry_stage_ff <= entry_stage_in;
         entry_name_ff  <= entry_name_in;
      end
   end

   assign rsp_placed_rank = placed_rank_ff;
   assign rsp_entry_score = entry_score_ff;
   assign rsp_entry_stage = entry_stage_ff;
   assign rsp_entry_name  = entry_name_ff;

   always_comb begin
      sorted_ok = 1'b1;
      for (int i = 1; i < NUM_ENTRIES; i++) begin
         if (score_tab_ff[i] > score_tab_ff[i-1]) begin
            sorted_ok = 1'b0;
         end
      end
   end

   a_table_sorted: assert property (@(posedge clock) disable iff (reset)
      sorted_ok)
      else $error("score table is not in descending order");

   a_add_updates_last_rank: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && (mode_ff == MODE_ADD)) |=> (rsp_placed_rank == last_rank_ff))
      else $error("reported rank of an add differs from the stored last rank");

   a_add_zero_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && (mode_ff == MODE_ADD)) |=>
         ((rsp_entry_score == '0) && (rsp_entry_stage == '0) && (rsp_entry_name == '0)))
      else $error("add response carries nonzero entry fields");

endmodule

FILE: rtl/core/top_n_sorted_score_table.sv
// ----------------------------------------------------------------------------
// Top-N sorted score table
// Keeps the best scores in descending order and answers add and read words.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge with start high and busy low. Mode add
// ranks req_score against the table (ties go behind older entries), inserts
// the record if the rank is below the table size and reports the rank on
// rsp_placed_rank; the entry fields are then zero. Mode read returns the
// entry at req_read_rank, with the last add rank on rsp_placed_rank.
// Each word is captured, then the datapath compares all entries at once
// and shifts the table, and then the response is shown. rsp_valid is
// high for a single cycle; busy stays high while it is shown and drops
// after it, so a new word is taken only once the last one is through.
// The receiver cannot hold a response off and must take it when
// rsp_valid is high. Synchronous reset refills the table with scores from
// ten times the table size down to ten, stage zero and blank names, and
// sets the last add rank to the table size.
// ----------------------------------------------------------------------------
module top_n_sorted_score_table
   import nsst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [31:0] req_score,
   input  logic [7:0]  req_stage,
   input  logic [23:0] req_name_chars,
   input  logic [2:0]  req_read_rank,
   output logic        rsp_valid,
   output logic [3:0]  rsp_placed_rank,
   output logic [31:0] rsp_entry_score,
   output logic [7:0]  rsp_entry_stage,
   output logic [23:0] rsp_entry_name
);

   dp_cmd_type cmd;

   nsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   nsst_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_score       (req_score),
      .req_stage       (req_stage),
      .req_name_chars  (req_name_chars),
      .req_read_rank   (req_read_rank),
      .rsp_placed_rank (rsp_placed_rank),
      .rsp_entry_score (rsp_entry_score),
      .rsp_entry_stage (rsp_entry_stage),
      .rsp_entry_name  (rsp_entry_name)
   );

endmodule

FILE: sim/top_n_sorted_score_table_test.sv
// ----------------------------------------------------------------------------
// Top-N sorted score table testbench
// Drives add and read words through the start/busy port and predicts every
// response with a local copy of the ranked table. Each response is checked
// field by field against the oldest prediction. A directed part covers the
// reset contents, extreme fields and ties. A random part follows, with
// random sender gaps and one full drain.
// ----------------------------------------------------------------------------
module top_n_sorted_score_table_test
   import nsst_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 2000;

   typedef struct {
      logic [3:0]  placed_rank;
      logic [31:0] entry_score;
      logic [7:0]  entry_stage;
      logic [23:0] entry_name;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic [31:0] req_score;
   logic [7:0]  req_stage;
   logic [23:0] req_name_chars;
   logic [2:0]  req_read_rank;
   logic        rsp_valid;
   logic [3:0]  rsp_placed_rank;
   logic [31:0] rsp_entry_score;
   logic [7:0]  rsp_entry_stage;
   logic [23:0] rsp_entry_name;

   logic [31:0] score_tab [NUM_ENTRIES];
   logic [7:0]  stage_tab [NUM_ENTRIES];
   logic [23:0] name_tab  [NUM_ENTRIES];
   logic [3:0]  last_add_rank;

   answer_type pending_answers [$];
   int errors;
   int cycle_count;
   int add_count;
   int placed_count;
   int read_count;
   bit idling_on;

   top_n_sorted_score_table DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_score       (req_score),
      .req_stage       (req_stage),
      .req_name_chars  (req_name_chars),
      .req_read_rank   (req_read_rank),
      .rsp_valid       (rsp_valid),
      .rsp_placed_rank (rsp_placed_rank),
      .rsp_entry_score (rsp_entry_score),
      .rsp_entry_stage (rsp_entry_stage),
      .rsp_entry_name  (rsp_entry_name)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void reset_table();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         score_tab[i] = (NUM_ENTRIES - i) * SCORE_STEP;
         stage_tab[i] = 8'd0;
         name_tab[i]  = BLANK_NAME;
      end
      last_add_rank = 4'(NUM_ENTRIES);
   endfunction

   // Applies one accepted word to the local table and returns its response.
   function automatic answer_type rank_and_insert(mode_type m, logic [31:0] sc,
                                                  logic [7:0] st, logic [23:0] nm,
                                                  logic [2:0] rr);
      answer_type a;
      int r;
      r = 0;
      a = '{4'd0, 32'd0, 8'd0, 24'd0};
      if (m == MODE_ADD) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (score_tab[i] >= sc) r++;
         end
         if (r < NUM_ENTRIES) begin
            for (int i = NUM_ENTRIES - 1; i > r; i--) begin
               score_tab[i] = score_tab[i-1];
               stage_tab[i] = stage_tab[i-1];
               name_tab[i]  = name_tab[i-1];
            end
            score_tab[r] = sc;
            stage_tab[r] = st;
            name_tab[r]  = nm;
         end
         last_add_rank = 4'(r);
         a.placed_rank = last_add_rank;
      end else begin
         a.placed_rank = last_add_rank;
         if (rr < NUM_ENTRIES) begin
            a.entry_score = score_tab[rr];
            a.entry_stage = stage_tab[rr];
            a.entry_name  = name_tab[rr];
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("response with no word pending: rank %0d score %h",
                   rsp_placed_rank, rsp_entry_score);
            errors++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_placed_rank !== e.placed_rank) begin
               $error("placed_rank: expected %0d, actual %0d", e.placed_rank,
                      rsp_placed_rank);
               errors++;
            end
            if (rsp_entry_score !== e.entry_score) begin
               $error("entry_score: expected %h, actual %h", e.entry_score,
                      rsp_entry_score);
               errors++;
            end
            if (rsp_entry_stage !== e.entry_stage) begin
               $error("entry_stage: expected %h, actual %h", e.entry_stage,
                      rsp_entry_stage);
               errors++;
            end
            if (rsp_entry_name !== e.entry_name) begin
               $error("entry_name: expected %h, actual %h", e.entry_name,
                      rsp_entry_name);
               errors++;
            end
         end
      end
   end

   task automatic send_word(mode_type m, logic [31:0] sc, logic [7:0] st,
                            logic [23:0] nm, logic [2:0] rr);
      answer_type expected;
      start          <= 1'b1;
      req_mode       <= m;
      req_score      <= sc;
      req_stage      <= st;
      req_name_chars <= nm;
      req_read_rank  <= rr;
      do @(posedge clock); while (busy);
      expected = rank_and_insert(m, sc, st, nm, rr);
      pending_answers.insert(pending_answers.size(), expected);
      if (m == MODE_ADD) begin
         add_count++;
         if (expected.placed_rank < NUM_ENTRIES) placed_count++;
      end else begin
         read_count++;
      end
   endtask

   task automatic sender_gap();
      if (idling_on && $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_answers();
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic read_whole_table();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         send_word(MODE_READ, $urandom, 8'($urandom), 24'($urandom), 3'(i));
         sender_gap();
      end
   endtask

   task automatic test_reset_contents();
      read_whole_table();
   endtask

   task automatic test_extremes_and_ties();
      send_word(MODE_ADD, 32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 3'd7);
      send_word(MODE_ADD, 32'd0, 8'd0, 24'd0, 3'd0);
      send_word(MODE_ADD, 32'd80, 8'd1, 24'h41_4243, 3'd0);
      send_word(MODE_ADD, 32'd80, 8'd2, 24'h44_4546, 3'd5);
      send_word(MODE_ADD, 32'd55, 8'h80, 24'h5A_5A5A, 3'd2);
      send_word(MODE_ADD, 32'd30, 8'h7F, 24'h20_2020, 3'd1);
      read_whole_table();
   endtask

   function automatic logic [31:0] pick_score();
      int sel;
      logic [31:0] base;
      sel  = $urandom_range(0, 99);
      base = score_tab[$urandom_range(0, NUM_ENTRIES - 1)];
      if (sel < 40) return base;
      if (sel < 55) return base + $urandom_range(1, 3);
      if (sel < 65) return base - $urandom_range(1, 3);
      if (sel < 70) return 32'd0;
      if (sel < 73) return 32'hFFFF_FFFF;
      if (sel < 78) return $urandom_range(0, 100);
      return $urandom;
   endfunction

   task automatic test_random_words();
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         idling_on = !(n >= 600 && n < 1000);
         if (n == 1200) drain_answers();
         if ($urandom_range(0, 99) < 55)
            send_word(MODE_ADD, pick_score(), 8'($urandom), 24'($urandom),
                      3'($urandom));
         else
            send_word(MODE_READ, $urandom, 8'($urandom), 24'($urandom),
                      3'($urandom_range(0, NUM_ENTRIES - 1)));
         sender_gap();
      end
      idling_on = 1'b1;
   endtask

   initial begin
      errors         = 0;
      cycle_count    = 0;
      add_count      = 0;
      placed_count   = 0;
      read_count     = 0;
      idling_on      = 1'b1;
      reset          = 1'b1;
      start          = 1'b0;
      req_mode       = MODE_ADD;
      req_score      = 32'd0;
      req_stage      = 8'd0;
      req_name_chars = 24'd0;
      req_read_rank  = 3'd0;
      reset_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_contents();
      test_extremes_and_ties();
      test_random_words();

      drain_answers();
      repeat (10) @(posedge clock);

      $display("Covered %0d add words (%0d placed) and %0d read words.",
               add_count, placed_count, read_count);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
